// ===== src/brb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brb_pkg
// Shared types and constants for the burst byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

   localparam int IDX_W     = 5;   // ring index and capacity width
   localparam int CNT_W     = 4;   // burst byte count width
   localparam int BYTE_W    = 8;
   localparam int DATA_W    = 64;  // packed burst data
   localparam int LANE_W    = 3;   // byte lane within the packed word
   localparam int MAX_BURST = 8;
   localparam int DEPTH_DEF = 32;

   localparam logic [IDX_W-1:0] CAP_RESET = 5'd31;
   localparam logic [IDX_W-1:0] WR_IDX_RESET = 5'd1;
   localparam logic [IDX_W-1:0] RD_IDX_RESET = 5'd0;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // Requests from the sequencer to the index unit.
   typedef struct packed {
      logic step;      // advance the selected index by one slot
      logic sel_read;  // 1 selects the read index, 0 the write index
   } ptr_ctrl_type;

   // Index unit view for the sequencer.
   typedef struct packed {
      logic [IDX_W-1:0] cur_idx;   // selected index, reduced to the ring
      logic [IDX_W-1:0] next_idx;  // selected index plus one, wrapped
      logic [IDX_W-1:0] fill;      // bytes held
      logic [IDX_W-1:0] room;      // usable bytes in the ring
   } ptr_stat_type;

endpackage

`default_nettype wire

// ===== src/byte_ring_buffer_burst.sv =====
`default_nettype none
// The block takes a new burst only in the idle state, after the result of
// the last one is loaded; a read burst passes a drain state first, and a
// rejected or empty burst goes straight to the done state. The single ring
// memory moves one byte per cycle.
// Reset: capacity 31, write index 1, read index 0 (empty ring); the byte
// store is not cleared, and there is no clearing pass.
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst
// Byte ring buffer that takes write and read bursts of up to eight bytes,
// all or nothing, and returns status, read bytes and fill for each burst.
// ----------------------------------------------------------------------------
module byte_ring_buffer_burst #(
   parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_cmd,
   input  wire logic [brb_pkg::CNT_W-1:0]    req_count,
   input  wire logic [brb_pkg::DATA_W-1:0]   req_data_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_status,
   output logic      [brb_pkg::DATA_W-1:0]   rsp_data_out,
   output logic      [brb_pkg::IDX_W-1:0]    rsp_fill,
   input  wire logic                         csr_write_enable,
   input  wire logic [brb_pkg::IDX_W-1:0]    csr_write_data
);

   import brb_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   ptr_ctrl_type      ctrl;
   ptr_stat_type      stat;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [BYTE_W-1:0] ram_rd_data;

   brb_ptr #(
      .DEPTH(DEPTH)
   ) u_ptr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .ctrl             (ctrl),
      .stat             (stat)
   );

   brb_ram #(
      .WIDTH(BYTE_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_addr    (ram_rd_addr),
      .rd_data_ff (ram_rd_data)
   );

   brb_seq #(
      .DEPTH(DEPTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_count    (req_count),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_fill     (rsp_fill),
      .stat         (stat),
      .ctrl         (ctrl),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

endmodule

`default_nettype wire

// ===== src/brb_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/brb_ptr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brb_ptr
// Capacity register, ring indices and the shared wrap-increment unit that
// steps either index by one slot per cycle.
// ----------------------------------------------------------------------------
module brb_ptr #(
   parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_enable,
   input  wire logic [brb_pkg::IDX_W-1:0]   csr_write_data,
   input  wire brb_pkg::ptr_ctrl_type       ctrl,
   output brb_pkg::ptr_stat_type            stat
);

   import brb_pkg::*;

   localparam int SLOT_LIMIT = (DEPTH > (1 << IDX_W)) ? (1 << IDX_W) : DEPTH;
   localparam logic [IDX_W:0] SLOT_CAP = (IDX_W+1)'(SLOT_LIMIT);

   logic [IDX_W-1:0] cap_ff;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;

   logic [IDX_W:0]   cap_p1;
   logic [IDX_W:0]   slots;
   logic [IDX_W-1:0] wr_mod;
   logic [IDX_W:0]   diff;
   logic [IDX_W:0]   fill_w;
   logic [IDX_W-1:0] src;
   logic [IDX_W:0]   inc;
   logic [IDX_W-1:0] nxt;

   always_comb begin
      cap_p1 = {1'b0, cap_ff} + (IDX_W+1)'(1);
      slots  = (cap_p1 > SLOT_CAP) ? SLOT_CAP : cap_p1;

      // The write index sits beyond the ring only when the ring has one slot.
      wr_mod = ({1'b0, wr_idx_ff} >= slots) ? '0 : wr_idx_ff;

      diff   = {1'b0, wr_mod} + slots - {1'b0, rd_idx_ff} - (IDX_W+1)'(1);
      fill_w = (diff >= slots) ? (diff - slots) : diff;

      src = ctrl.sel_read ? rd_idx_ff : wr_mod;
      inc = {1'b0, src} + (IDX_W+1)'(1);
      nxt = (inc == slots) ? '0 : inc[IDX_W-1:0];

      stat.cur_idx  = src;
      stat.next_idx = nxt;
      stat.fill     = fill_w[IDX_W-1:0];
      stat.room     = IDX_W'(slots - (IDX_W+1)'(1));
   end

   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      if (csr_write_enable) begin
         wr_idx_in = WR_IDX_RESET;
         rd_idx_in = RD_IDX_RESET;
      end else if (ctrl.step) begin
         if (ctrl.sel_read) begin
            rd_idx_in = nxt;
         end else begin
            wr_idx_in = nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         wr_idx_ff <= WR_IDX_RESET;
         rd_idx_ff <= RD_IDX_RESET;
      end else begin
         if (csr_write_enable) begin
            cap_ff <= csr_write_data;
         end
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/brb_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// brb_seq
// Burst sequencer: admission check, one byte per cycle through the ring
// memory, read data collection and the result register.
// ----------------------------------------------------------------------------
module brb_seq #(
   parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_cmd,
   input  wire logic [brb_pkg::CNT_W-1:0]    req_count,
   input  wire logic [brb_pkg::DATA_W-1:0]   req_data_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_status,
   output logic      [brb_pkg::DATA_W-1:0]   rsp_data_out,
   output logic      [brb_pkg::IDX_W-1:0]    rsp_fill,
   input  wire brb_pkg::ptr_stat_type        stat,
   output brb_pkg::ptr_ctrl_type             ctrl,
   output logic                              ram_wr_en,
   output logic      [$clog2(DEPTH)-1:0]     ram_wr_addr,
   output logic      [brb_pkg::BYTE_W-1:0]   ram_wr_data,
   output logic                              ram_rd_en,
   output logic      [$clog2(DEPTH)-1:0]     ram_rd_addr,
   input  wire logic [brb_pkg::BYTE_W-1:0]   ram_rd_data
);

   import brb_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   state_type state_ff, state_in;

   logic              cmd_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [DATA_W-1:0] data_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              status_ff;
   logic [DATA_W-1:0] acc_ff;
   logic              cap_valid_ff;
   logic [LANE_W-1:0] cap_lane_ff;
   logic              rsp_valid_ff;
   logic              rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [IDX_W-1:0]  rsp_fill_ff;

   logic              accept;
   logic              over_max;
   logic              wr_reject;
   logic              rd_reject;
   logic              reject;
   logic              last_byte;
   logic              rsp_load;
   logic [LANE_W-1:0] lane;

   always_comb begin
      accept    = (state_ff == ST_IDLE) && req_valid;
      over_max  = req_count > CNT_W'(MAX_BURST);
      wr_reject = ({1'b0, stat.fill} + {2'b0, req_count}) > {1'b0, stat.room};
      rd_reject = {1'b0, req_count} > stat.fill;
      reject    = over_max || ((req_cmd == CMD_READ) ? rd_reject : wr_reject);
      last_byte = (cnt_ff + CNT_W'(1)) == count_ff;
      lane      = cnt_ff[LANE_W-1:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (reject || (req_count == '0)) begin
                  state_in = ST_DONE;
               end else if (req_cmd == CMD_READ) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_WRITE;
               end
            end
         end
         ST_WRITE: begin
            if (last_byte) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            if (last_byte) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: state_in = ST_DONE;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_stall     = 1'b1;
      ctrl.step     = 1'b0;
      ctrl.sel_read = (cmd_ff == CMD_READ);
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      rsp_load      = 1'b0;
      ram_wr_addr   = ADDR_W'(stat.cur_idx);
      ram_rd_addr   = ADDR_W'(stat.next_idx);
      ram_wr_data   = data_ff[lane*BYTE_W +: BYTE_W];
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_WRITE: begin
            ram_wr_en = 1'b1;
            ctrl.step = 1'b1;
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            ctrl.step = 1'b1;
         end
         ST_DRAIN: ;
         ST_DONE:  rsp_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_valid_ff <= (state_ff == ST_READ);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cap_lane_ff <= lane;
      if (accept) begin
         cmd_ff    <= req_cmd;
         count_ff  <= req_count;
         data_ff   <= req_data_in;
         cnt_ff    <= '0;
         status_ff <= reject ? STATUS_REJECT : STATUS_OK;
         acc_ff    <= '0;
      end else begin
         if ((state_ff == ST_WRITE) || (state_ff == ST_READ)) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         // Read data returns in the cycle after its address was issued.
         if (cap_valid_ff) begin
            acc_ff[cap_lane_ff*BYTE_W +: BYTE_W] <= ram_rd_data;
         end
      end
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= acc_ff;
         rsp_fill_ff   <= stat.fill;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_data_out = rsp_data_ff;
   assign rsp_fill     = rsp_fill_ff;

endmodule

`default_nettype wire

// ===== dv/byte_ring_buffer_burst_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_buffer_burst_tb
// Drives write and read bursts into the byte ring buffer under several
// capacity settings, predicts status, read bytes and fill for every transfer,
// and compares each returned result with the oldest prediction.
// ----------------------------------------------------------------------------
module byte_ring_buffer_burst_tb;

   import brb_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic              status;
      logic [DATA_W-1:0] data_out;
      logic [IDX_W-1:0]  fill;
   } burst_result_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_cmd = CMD_WRITE;
   logic [CNT_W-1:0]  req_count = '0;
   logic [DATA_W-1:0] req_data_in = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_status;
   logic [DATA_W-1:0] rsp_data_out;
   logic [IDX_W-1:0]  rsp_fill;
   logic              csr_write_enable = 1'b0;
   logic [IDX_W-1:0]  csr_write_data = '0;

   // Predicted ring state.
   logic [BYTE_W-1:0] ring_bytes [DEPTH_DEF];
   int unsigned       ring_capacity = CAP_RESET;
   int unsigned       ring_wr_idx = WR_IDX_RESET;
   int unsigned       ring_rd_idx = RD_IDX_RESET;

   burst_result_type  results_due [$];

   bit idling_on = 1'b0;
   int stall_left = 0;
   int mismatch_count = 0;
   int bursts_sent = 0;
   int bursts_accepted = 0;
   int bursts_rejected = 0;
   int results_checked = 0;
   int capacity_writes = 0;
   int cycle_count = 0;

   byte_ring_buffer_burst dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_count        (req_count),
      .req_data_in      (req_data_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_data_out     (rsp_data_out),
      .rsp_fill         (rsp_fill),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int unsigned ring_slots();
      int unsigned slots;
      slots = ring_capacity + 1;
      if (slots > DEPTH_DEF) slots = DEPTH_DEF;
      return slots;
   endfunction

   function automatic int unsigned ring_fill(int unsigned slots);
      return (slots + (ring_wr_idx % slots) - (ring_rd_idx % slots) - 1) % slots;
   endfunction

   // Works out the result of one transferred burst and advances the ring state.
   function automatic void apply_burst(logic cmd, logic [CNT_W-1:0] cnt,
                                       logic [DATA_W-1:0] data);
      int unsigned      slots;
      int unsigned      used;
      int unsigned      pos;
      burst_result_type res;
      slots = ring_slots();
      used = ring_fill(slots);
      res = '0;
      res.status = STATUS_OK;
      if (cnt > MAX_BURST) begin
         res.status = STATUS_REJECT;
      end else if (cmd == CMD_WRITE) begin
         if (used + cnt > slots - 1) begin
            res.status = STATUS_REJECT;
         end else begin
            for (int i = 0; i < cnt; i++) begin
               pos = ring_wr_idx % slots;
               ring_bytes[pos % DEPTH_DEF] = data[BYTE_W*i +: BYTE_W];
               ring_wr_idx = (pos + 1) % slots;
            end
         end
      end else begin
         if (cnt > used) begin
            res.status = STATUS_REJECT;
         end else begin
            for (int i = 0; i < cnt; i++) begin
               pos = ((ring_rd_idx % slots) + 1) % slots;
               res.data_out[BYTE_W*i +: BYTE_W] = ring_bytes[pos % DEPTH_DEF];
               ring_rd_idx = pos;
            end
         end
      end
      res.fill = IDX_W'(ring_fill(slots));
      if (res.status == STATUS_OK) bursts_accepted++;
      else bursts_rejected++;
      results_due.push_back(res);
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                  input logic [DATA_W-1:0] got);
      $display("ERROR at cycle %0d: %s expected 0x%0h, got 0x%0h",
               cycle_count, what, want, got);
      mismatch_count++;
   endtask

   // Presents one burst and holds it until the transfer takes place.
   task automatic send_burst(input logic cmd, input logic [CNT_W-1:0] cnt,
                             input logic [DATA_W-1:0] data);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_cmd = cmd;
      req_count = cnt;
      req_data_in = data;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      apply_burst(cmd, cnt, data);
      bursts_sent++;
   endtask

   // Stops presenting bursts and waits until no result is outstanding, and
   // then lets the clock run on before returning.
   task automatic wait_until_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (results_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_capacity(input int unsigned value);
      wait_until_idle();
      csr_write_data = IDX_W'(value);
      csr_write_enable = 1'b1;
      @(negedge clock);
      csr_write_enable = 1'b0;
      ring_capacity = value;
      ring_wr_idx = WR_IDX_RESET;
      ring_rd_idx = RD_IDX_RESET;
      capacity_writes++;
   endtask

   function automatic logic [DATA_W-1:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   task automatic test_empty_and_count_limits();
      send_burst(CMD_READ, 0, '0);
      send_burst(CMD_READ, 1, '0);
      send_burst(CMD_WRITE, 0, '1);
      send_burst(CMD_WRITE, 15, '1);
      send_burst(CMD_WRITE, 9, random_word());
      send_burst(CMD_READ, 9, '0);
   endtask

   task automatic test_fill_to_capacity();
      send_burst(CMD_WRITE, 8, '1);
      send_burst(CMD_WRITE, 8, '0);
      send_burst(CMD_WRITE, 8, 64'hA5A5_5A5A_0F0F_F0F0);
      send_burst(CMD_WRITE, 7, random_word());
      send_burst(CMD_WRITE, 1, '1);
      send_burst(CMD_WRITE, 0, '1);
      send_burst(CMD_READ, 8, '1);
      send_burst(CMD_READ, 8, '1);
      send_burst(CMD_READ, 8, '0);
      send_burst(CMD_READ, 7, '0);
      send_burst(CMD_READ, 1, '0);
   endtask

   task automatic test_capacity_extremes();
      // With no usable byte only empty bursts get through.
      write_capacity(0);
      send_burst(CMD_WRITE, 0, '1);
      send_burst(CMD_WRITE, 1, '1);
      send_burst(CMD_READ, 0, '0);
      send_burst(CMD_READ, 1, '0);
      write_capacity(1);
      send_burst(CMD_WRITE, 1, random_word());
      send_burst(CMD_WRITE, 1, random_word());
      send_burst(CMD_READ, 1, '0);
      send_burst(CMD_WRITE, 1, random_word());
      send_burst(CMD_READ, 1, '0);
   endtask

   // Reads and writes are weighted by how full the ring is, so most bursts
   // get through and the indices wrap many times.
   task automatic random_phase(input int unsigned capacity, input int n_items);
      int unsigned fill_now;
      logic        cmd;
      logic [CNT_W-1:0] cnt;
      write_capacity(capacity);
      for (int k = 0; k < n_items; k++) begin
         fill_now = ring_fill(ring_slots());
         if (fill_now * 2 < capacity) cmd = ($urandom_range(0, 9) < 7) ? CMD_WRITE : CMD_READ;
         else cmd = ($urandom_range(0, 9) < 7) ? CMD_READ : CMD_WRITE;
         if ($urandom_range(0, 9) == 0) cnt = CNT_W'($urandom_range(MAX_BURST + 1, 15));
         else cnt = CNT_W'($urandom_range(0, MAX_BURST));
         send_burst(cmd, cnt, random_word());
      end
   endtask

   task automatic test_random_traffic();
      idling_on = 1'b1;
      random_phase(31, 130);
      random_phase(1, 80);
      random_phase($urandom_range(2, 30), 130);
      random_phase(8, 130);
      random_phase($urandom_range(2, 30), 130);
      random_phase(31, 70);
      idling_on = 1'b0;
      random_phase($urandom_range(9, 31), 130);
   endtask

   always @(posedge clock) begin
      burst_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (results_due.size() == 0) begin
            report_mismatch("unexpected result, fill", '0, rsp_fill);
         end else begin
            want = results_due.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", want.status, rsp_status);
            if (rsp_data_out !== want.data_out)
               report_mismatch("data_out", want.data_out, rsp_data_out);
            if (rsp_fill !== want.fill) report_mismatch("fill", want.fill, rsp_fill);
            results_checked++;
         end
      end
   end

   always @(negedge clock) begin
      if (!idling_on || reset) begin
         rsp_stall = 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_stall = 1'b1;
         stall_left--;
      end else if ($urandom_range(0, 4) == 0) begin
         rsp_stall = 1'b1;
         stall_left = $urandom_range(0, 3);
      end else begin
         rsp_stall = 1'b0;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, results_due.size());
         $display("byte_ring_buffer_burst: mismatch");
         $finish;
      end
   end

   initial begin
      foreach (ring_bytes[i]) ring_bytes[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_and_count_limits();
      test_fill_to_capacity();
      test_capacity_extremes();
      test_random_traffic();
      wait_until_idle();
      $display("Sent %0d bursts (%0d accepted, %0d rejected) across %0d capacity writes.",
               bursts_sent, bursts_accepted, bursts_rejected, capacity_writes);
      $display("Checked %0d results, %0d field mismatches.", results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("byte_ring_buffer_burst: match");
      end else begin
         $display("byte_ring_buffer_burst: mismatch");
      end
      $finish;
   end

endmodule

`default_nettype wire
